### rtl/vaf_pkg.sv
// Shared types, widths and constants for the full-circle vector angle pipeline.
`timescale 1ns / 1ps
package vaf_pkg;

  // Port widths
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;

  // Default configuration
  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  // Internal datapath widths
  localparam int MAG_W   = COORD_W;  // |x|, |y| as unsigned
  localparam int SHIFT_W = 6;        // normalizing shift, 25..40
  localparam int CX_W    = 45;       // CORDIC x/y, magnitude below 2^43
  localparam int Z_W     = 33;       // signed Q30 angle accumulator
  localparam int T_W     = 31;       // clamped first-quadrant angle, Q30
  localparam int A_W     = 34;       // full-circle angle, Q30 unsigned
  localparam int NORM_MSB = 40;      // larger magnitude is moved to [2^40, 2^41)

  // Angle constants, Q30
  localparam logic [A_W-1:0] Q30_PI             = A_W'(64'd3373259426);
  localparam logic [A_W-1:0] Q30_HALF_PI        = A_W'(64'd1686629713);
  localparam logic [A_W-1:0] Q30_THREE_HALF_PI  = A_W'(64'd5059889139);
  localparam logic [A_W-1:0] Q30_TWO_PI         = A_W'(64'd6746518852);

  // round(atan(2^-i) * 2^30)
  localparam int ATAN_TABLE_LEN = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_TABLE_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // How the first-quadrant angle maps onto the full circle
  typedef enum logic [2:0] {
    FOLD_DIRECT,
    FOLD_PI_MINUS,
    FOLD_PI_PLUS,
    FOLD_TWO_PI_MINUS,
    FOLD_HALF_PI,
    FOLD_THREE_HALF_PI
  } fold_mode_t;

  // Side information that rides along with each transaction
  typedef struct packed {
    fold_mode_t mode;
    logic       t_zero;  // y is zero: first-quadrant angle is exactly 0
  } vaf_tag_t;

  // Largest output code for a given number of fraction bits
  function automatic logic [ANGLE_W-1:0] angle_top(input int frac_bits);
    logic [A_W-1:0] full;
    full = Q30_TWO_PI >> (30 - frac_bits);
    return (full > A_W'(17'h0FFFF)) ? {ANGLE_W{1'b1}} : full[ANGLE_W-1:0];
  endfunction

endpackage

### rtl/vaf_prep.sv
// Front end: absolute values and quadrant code, shift search, normalizing shift.
`timescale 1ns / 1ps
module vaf_prep
  import vaf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic signed [COORD_W-1:0]  x_coord,
  input  logic signed [COORD_W-1:0]  y_coord,
  output logic                       out_valid,
  output vaf_tag_t                   out_tag,
  output logic signed [CX_W-1:0]     out_cx,
  output logic signed [CX_W-1:0]     out_cy
);

  // Stage A registers
  logic             a_valid;
  vaf_tag_t         a_tag;
  logic [MAG_W-1:0] a_ax;
  logic [MAG_W-1:0] a_ay;

  // Stage B registers
  logic               b_valid;
  vaf_tag_t           b_tag;
  logic [MAG_W-1:0]   b_ax;
  logic [MAG_W-1:0]   b_ay;
  logic [SHIFT_W-1:0] b_shift;

  logic [MAG_W-1:0]   ax_next;
  logic [MAG_W-1:0]   ay_next;
  vaf_tag_t           tag_next;
  logic [MAG_W-1:0]   mag_max;
  logic [3:0]         msb;
  logic [SHIFT_W-1:0] shift_next;

  // Stage A: magnitudes and quadrant code
  always_comb begin
    ax_next = x_coord[COORD_W-1] ? MAG_W'(-x_coord) : MAG_W'(x_coord);
    ay_next = y_coord[COORD_W-1] ? MAG_W'(-y_coord) : MAG_W'(y_coord);
    tag_next.t_zero = (y_coord == '0);
    if (x_coord == '0) begin
      tag_next.mode = (!y_coord[COORD_W-1] && y_coord != '0) ? FOLD_HALF_PI
                                                             : FOLD_THREE_HALF_PI;
    end else if (!x_coord[COORD_W-1]) begin
      tag_next.mode = y_coord[COORD_W-1] ? FOLD_TWO_PI_MINUS : FOLD_DIRECT;
    end else begin
      tag_next.mode = y_coord[COORD_W-1] ? FOLD_PI_PLUS : FOLD_PI_MINUS;
    end
  end

  // Stage B: leading one of the larger magnitude
  always_comb begin
    mag_max = (a_ax > a_ay) ? a_ax : a_ay;
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_max[i]) msb = 4'(i);
    end
    shift_next = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      a_tag   <= tag_next;
      a_ax    <= ax_next;
      a_ay    <= ay_next;
      b_tag   <= a_tag;
      b_ax    <= a_ax;
      b_ay    <= a_ay;
      b_shift <= shift_next;
      out_tag <= b_tag;
      out_cx  <= CX_W'(b_ax) << b_shift;
      out_cy  <= CX_W'(b_ay) << b_shift;
    end
  end

endmodule

### rtl/vaf_cordic_stage.sv
// One registered CORDIC vectoring iteration.
`timescale 1ns / 1ps
module vaf_cordic_stage
  import vaf_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  vaf_tag_t               in_tag,
  input  logic signed [CX_W-1:0] in_cx,
  input  logic signed [CX_W-1:0] in_cy,
  input  logic signed [Z_W-1:0]  in_z,
  output logic                   out_valid,
  output vaf_tag_t               out_tag,
  output logic signed [CX_W-1:0] out_cx,
  output logic signed [CX_W-1:0] out_cy,
  output logic signed [Z_W-1:0]  out_z
);

  localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_Q30[STEP]);

  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  logic signed [CX_W-1:0] cx_next;
  logic signed [CX_W-1:0] cy_next;
  logic signed [Z_W-1:0]  z_next;

  // Rotate toward the x axis; shifts round toward minus infinity
  always_comb begin
    dx = in_cy >>> STEP;
    dy = in_cx >>> STEP;
    if (!in_cy[CX_W-1]) begin
      cx_next = in_cx + dx;
      cy_next = in_cy - dy;
      z_next  = in_z + ATAN_STEP;
    end else begin
      cx_next = in_cx - dx;
      cy_next = in_cy + dy;
      z_next  = in_z - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tag <= in_tag;
      out_cx  <= cx_next;
      out_cy  <= cy_next;
      out_z   <= z_next;
    end
  end

endmodule

### rtl/vaf_post.sv
// Back end: clamp, quadrant fold, rounding and saturation into the output register.
`timescale 1ns / 1ps
module vaf_post
  import vaf_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  vaf_tag_t              in_tag,
  input  logic signed [Z_W-1:0] in_z,
  output logic                  out_valid,
  output logic [ANGLE_W-1:0]    angle_rad
);

  localparam int                 SH        = 30 - ANGLE_FRAC_BITS;
  localparam logic [A_W:0]       ROUND_ADD = (A_W + 1)'(1) << (SH - 1);
  localparam logic [ANGLE_W-1:0] TOP       = angle_top(ANGLE_FRAC_BITS);

  logic               f_valid;
  logic [A_W-1:0]     f_angle;

  logic [T_W-1:0]     t;
  logic [A_W-1:0]     angle_next;
  logic [A_W:0]       rounded;
  logic [ANGLE_W-1:0] code_next;

  // Clamp to [0, pi/2] and fold into the quadrant
  always_comb begin
    if (in_tag.t_zero || in_z[Z_W-1]) begin
      t = '0;
    end else if (A_W'(in_z) > Q30_HALF_PI) begin
      t = T_W'(Q30_HALF_PI);
    end else begin
      t = T_W'(in_z);
    end
    case (in_tag.mode)
      FOLD_DIRECT:        angle_next = A_W'(t);
      FOLD_PI_MINUS:      angle_next = Q30_PI - A_W'(t);
      FOLD_PI_PLUS:       angle_next = Q30_PI + A_W'(t);
      FOLD_TWO_PI_MINUS:  angle_next = Q30_TWO_PI - A_W'(t);
      FOLD_HALF_PI:       angle_next = Q30_HALF_PI;
      FOLD_THREE_HALF_PI: angle_next = Q30_THREE_HALF_PI;
      default:            angle_next = '0;
    endcase
  end

  // Round half up, then saturate at the top code
  always_comb begin
    rounded   = ((A_W + 1)'(f_angle) + ROUND_ADD) >> SH;
    code_next = (rounded > (A_W + 1)'(TOP)) ? TOP : rounded[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      f_valid   <= in_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_angle   <= angle_next;
      angle_rad <= code_next;
    end
  end

endmodule

### rtl/vector_angle_full_circle.sv
// Top level: full-circle vector angle by a pipelined CORDIC.
// Pipeline from input transaction to out_valid: three front-end stages, one stage per
//   CORDIC iteration, two back-end stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous) clears every stage's valid bit; data registers are not reset.
`timescale 1ns / 1ps
module vector_angle_full_circle
  import vaf_pkg::*;
#(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ANGLE_W-1:0]        angle_rad
);

  localparam logic [ANGLE_W-1:0] TOP = angle_top(ANGLE_FRAC_BITS);

  logic advance;

  logic                   valid_chain [CORDIC_STEPS+1];
  vaf_tag_t               tag_chain   [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cx_chain    [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cy_chain    [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_chain     [CORDIC_STEPS+1];

  // Pipeline moves unless the output register holds an untaken result
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  vaf_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (valid_chain[0]),
    .out_tag   (tag_chain[0]),
    .out_cx    (cx_chain[0]),
    .out_cy    (cy_chain[0])
  );

  assign z_chain[0] = '0;

  // One register stage per iteration
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    vaf_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (valid_chain[i]),
      .in_tag    (tag_chain[i]),
      .in_cx     (cx_chain[i]),
      .in_cy     (cy_chain[i]),
      .in_z      (z_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_tag   (tag_chain[i+1]),
      .out_cx    (cx_chain[i+1]),
      .out_cy    (cy_chain[i+1]),
      .out_z     (z_chain[i+1])
    );
  end

  vaf_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (valid_chain[CORDIC_STEPS]),
    .in_tag    (tag_chain[CORDIC_STEPS]),
    .in_z      (z_chain[CORDIC_STEPS]),
    .out_valid (out_valid),
    .angle_rad (angle_rad)
  );

  // Output code never passes the saturation value
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_rad <= TOP)
    else $error("angle code above top of range");

  // A held result blocks new input transactions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output is stalled");

  // Reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

endmodule

### sim/testbench.sv
// Self-checking bench for the full-circle vector angle pipeline: random stalls on both sides.
`timescale 1ns / 1ps
module testbench;

  localparam int COORD_W    = vaf_pkg::COORD_W;
  localparam int ANGLE_W    = vaf_pkg::ANGLE_W;
  localparam int STEPS      = vaf_pkg::DEF_CORDIC_STEPS;
  localparam int FRAC_BITS  = vaf_pkg::DEF_ANGLE_FRAC_BITS;
  localparam int LATENCY    = STEPS + 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 530;

  // Angle constants, radians * 2^30
  localparam longint ANG_PI         = 64'sd3373259426;
  localparam longint ANG_HALF_PI    = 64'sd1686629713;
  localparam longint ANG_3_HALF_PI  = 64'sd5059889139;
  localparam longint ANG_TWO_PI     = 64'sd6746518852;
  localparam longint NORM_FLOOR     = 64'sd1 <<< 40;

  // round(atan(2^-i) * 2^30)
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vec_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ANGLE_W-1:0]        angle;
  } angle_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] x_coord = '0;
  logic signed [COORD_W-1:0] y_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ANGLE_W-1:0] angle_rad;

  vec_t       pending_vecs[$];
  angle_exp_t expected_angles[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_started = 1'b0;
  int hold_cnt = 0;
  int mismatch_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int cycle_cnt = 0;

  vector_angle_full_circle #(
    .CORDIC_STEPS    (STEPS),
    .ANGLE_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_rad (angle_rad)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Expected angle: CORDIC vectoring on the first quadrant, then fold and round
  function automatic logic [ANGLE_W-1:0] predict_angle(input logic signed [COORD_W-1:0] xc,
                                                       input logic signed [COORD_W-1:0] yc);
    longint x, y, ax, ay, cx, cy, dx, dy, z, m, t, a, r, top;
    int s, i, sh;
    x = xc;
    y = yc;
    sh = 30 - FRAC_BITS;
    if (x == 0) begin
      a = (y > 0) ? ANG_HALF_PI : ANG_3_HALF_PI;
    end else begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      t = 0;
      if (ay != 0) begin
        m = (ax > ay) ? ax : ay;
        s = 0;
        while (m < NORM_FLOOR) begin
          m = m <<< 1;
          s++;
        end
        cx = ax <<< s;
        cy = ay <<< s;
        z = 0;
        for (i = 0; i < ((STEPS > 24) ? 24 : STEPS); i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy >= 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z = z + longint'(ARCTAN_STEP[i]);
          end else begin
            cx = cx - dx;
            cy = cy + dy;
            z = z - longint'(ARCTAN_STEP[i]);
          end
        end
        if (z < 0) z = 0;
        if (z > ANG_HALF_PI) z = ANG_HALF_PI;
        t = z;
      end
      if (x > 0) a = (y >= 0) ? t : ANG_TWO_PI - t;
      else a = (y >= 0) ? ANG_PI - t : ANG_PI + t;
    end
    if (a < 0) a = 0;
    r = (a + (64'sd1 <<< (sh - 1))) >>> sh;
    top = ANG_TWO_PI >>> sh;
    if (top > 65535) top = 65535;
    if (r > top) r = top;
    return r[ANGLE_W-1:0];
  endfunction

  // Driver: offer queued vectors, record what the block takes
  always @(posedge clk) begin
    vec_t v;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_angles.push_back('{x_coord, y_coord, predict_angle(x_coord, y_coord)});
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_vecs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          v = pending_vecs.pop_front();
          in_valid <= 1'b1;
          x_coord  <= v.x;
          y_coord  <= v.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, counted down on its own
  always @(posedge clk) begin
    if (hold_req && !hold_started) begin
      hold_cnt <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    angle_exp_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: unexpected angle %0d with nothing outstanding", angle_rad);
        end else begin
          e = expected_angles.pop_front();
          checked_cnt++;
          if (angle_rad !== e.angle) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: x=%0d y=%0d angle expected %0d got %0d",
                       e.x, e.y, e.angle, angle_rad);
          end
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Random vector, weighted toward axes, diagonals and tiny magnitudes
  function automatic vec_t rand_vec();
    vec_t v;
    int pick;
    pick = $urandom_range(99);
    v.x = COORD_W'($urandom);
    v.y = COORD_W'($urandom);
    if (pick < 15) begin
      v.x = COORD_W'($signed($urandom_range(16)) - 8);
      v.y = COORD_W'($signed($urandom_range(16)) - 8);
    end else if (pick < 22) begin
      v.x = '0;
    end else if (pick < 29) begin
      v.y = '0;
    end else if (pick < 37) begin
      v.y = ($urandom_range(1)) ? v.x : -v.x;
    end else if (pick < 42) begin
      v.y = COORD_W'($signed($urandom_range(2)) - 1);
    end
    return v;
  endfunction

  task automatic queue_random(input int n);
    int k;
    for (k = 0; k < n; k++) pending_vecs.push_back(rand_vec());
  endtask

  task automatic wait_sent();
    while (pending_vecs.size() != 0) @(negedge clk);
  endtask

  // Sequencer
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sender idles rarely, receiver often
    send_idle_pct = 23;
    recv_idle_pct = 72;
    // axes, zero vector, extremes, near-2pi saturation, diagonals
    pending_vecs.push_back('{16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd1});
    pending_vecs.push_back('{16'sd0, -16'sd1});
    pending_vecs.push_back('{16'sd0, 16'sd32767});
    pending_vecs.push_back('{16'sd0, -16'sd32768});
    pending_vecs.push_back('{16'sd1, 16'sd0});
    pending_vecs.push_back('{-16'sd1, 16'sd0});
    pending_vecs.push_back('{16'sd32767, 16'sd0});
    pending_vecs.push_back('{-16'sd32768, 16'sd0});
    pending_vecs.push_back('{16'sd32767, 16'sd32767});
    pending_vecs.push_back('{-16'sd32768, -16'sd32768});
    pending_vecs.push_back('{16'sd32767, -16'sd32768});
    pending_vecs.push_back('{-16'sd32768, 16'sd32767});
    pending_vecs.push_back('{16'sd32767, -16'sd1});
    pending_vecs.push_back('{16'sd32767, 16'sd1});
    pending_vecs.push_back('{-16'sd32768, -16'sd1});
    pending_vecs.push_back('{-16'sd32768, 16'sd1});
    pending_vecs.push_back('{16'sd1, 16'sd32767});
    pending_vecs.push_back('{-16'sd1, -16'sd32768});
    pending_vecs.push_back('{16'sd1, 16'sd1});
    pending_vecs.push_back('{-16'sd1, 16'sd1});
    pending_vecs.push_back('{-16'sd1, -16'sd1});
    pending_vecs.push_back('{16'sd1, -16'sd1});
    queue_random(RANDOM_PER_PHASE);
    wait_sent();

    // Phase two: roles swapped
    send_idle_pct = 72;
    recv_idle_pct = 23;
    queue_random(RANDOM_PER_PHASE);
    wait_sent();

    // Phase three: full rate, opening with a long output stall to back up the pipe
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    hold_req = 1'b1;
    wait_sent();

    // Drain
    while (expected_angles.size() != 0 || in_valid) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
    if (expected_angles.size() != 0) begin
      mismatch_cnt++;
      $display("ERROR: %0d angles never came out", expected_angles.size());
    end

    $display("Covered %0d vectors (axes, zero vector, extremes, diagonals, near-2pi) and",
             sent_cnt);
    $display("checked %0d angles under three stall mixes plus one %0d-cycle output hold.",
             checked_cnt, HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
